// File: rtl/sdik_pkg.sv
// Shared types, constants and the arctangent table of the swerve-drive kinematics block.
// Used by sdik_ctrl, sdik_datapath and the top level; depends on nothing else.
package sdik_pkg;

    localparam int NUM_WHEELS   = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam logic [4:0] LAST_ITER = 5'(CORDIC_ITERS - 1);

    localparam int IN_W  = 72;
    localparam int OUT_W = 256;
    localparam int CFG_W = 32;

    // Fine CORDIC angles use pi = 2^30.
    localparam logic signed [31:0] HALF_PI_FINE = 32'sd536870912;
    localparam logic signed [31:0] INV_GAIN     = 32'sd652032875;

    localparam logic [1:0] CFG_HALF_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_HALF_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_INV_RADIUS   = 2'd2;
    localparam logic [1:0] CFG_MIN_SPEED_SQ = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_W,
        CMD_MUL_L,
        CMD_SAVE_L,
        CMD_VEL,
        CMD_SQ_X,
        CMD_SQ_Y,
        CMD_VEC_INIT,
        CMD_ROT_INIT,
        CMD_ITER,
        CMD_ANGLE,
        CMD_MUL_GAIN,
        CMD_RND_GAIN,
        CMD_MUL_RAD,
        CMD_SPEED,
        CMD_PUBLISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [1:0] wheel;
        logic [4:0] iter;
        logic       vec;
    } dp_cmd_t;

    typedef struct packed {
        logic big;
        logic out_busy;
    } dp_status_t;

    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd268435456;
            5'd1:  v = 32'sd158466703;
            5'd2:  v = 32'sd83729454;
            5'd3:  v = 32'sd42502379;
            5'd4:  v = 32'sd21333665;
            5'd5:  v = 32'sd10677233;
            5'd6:  v = 32'sd5339919;
            5'd7:  v = 32'sd2670123;
            5'd8:  v = 32'sd1335082;
            5'd9:  v = 32'sd667543;
            5'd10: v = 32'sd333772;
            5'd11: v = 32'sd166886;
            5'd12: v = 32'sd83443;
            5'd13: v = 32'sd41722;
            5'd14: v = 32'sd20861;
            5'd15: v = 32'sd10430;
            5'd16: v = 32'sd5215;
            5'd17: v = 32'sd2608;
            5'd18: v = 32'sd1304;
            5'd19: v = 32'sd652;
            5'd20: v = 32'sd326;
            5'd21: v = 32'sd163;
            5'd22: v = 32'sd81;
            5'd23: v = 32'sd41;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/sdik_ctrl.sv
// Sequencer of the swerve-drive kinematics block: one-hot state machine issuing datapath commands.
// Depends on sdik_pkg.
module sdik_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sdik_pkg::dp_status_t status,
    output sdik_pkg::dp_cmd_t   cmd
);
    import sdik_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_MULW  = 18'h00002,
        S_MULL  = 18'h00004,
        S_SAVEL = 18'h00008,
        S_VEL   = 18'h00010,
        S_SQX   = 18'h00020,
        S_SQY   = 18'h00040,
        S_MAG   = 18'h00080,
        S_VINIT = 18'h00100,
        S_VITER = 18'h00200,
        S_ANGLE = 18'h00400,
        S_RINIT = 18'h00800,
        S_RITER = 18'h01000,
        S_MULG  = 18'h02000,
        S_RNDG  = 18'h04000,
        S_MULR  = 18'h08000,
        S_SPD   = 18'h10000,
        S_DONE  = 18'h20000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] iter_reg, iter_next;
    logic [1:0] wheel_reg, wheel_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        wheel_next = wheel_reg;
        cmd.op     = CMD_NONE;
        cmd.wheel  = wheel_reg;
        cmd.iter   = iter_reg;
        cmd.vec    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = CMD_LOAD;
                    wheel_next = 2'd0;
                    state_next = S_MULW;
                end
            end
            S_MULW: begin
                cmd.op     = CMD_MUL_W;
                state_next = S_MULL;
            end
            S_MULL: begin
                cmd.op     = CMD_MUL_L;
                state_next = S_SAVEL;
            end
            S_SAVEL: begin
                cmd.op     = CMD_SAVE_L;
                state_next = S_VEL;
            end
            S_VEL: begin
                cmd.op     = CMD_VEL;
                state_next = S_SQX;
            end
            S_SQX: begin
                cmd.op     = CMD_SQ_X;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.op     = CMD_SQ_Y;
                state_next = S_MAG;
            end
            S_MAG: begin
                state_next = status.big ? S_VINIT : S_RINIT;
            end
            S_VINIT: begin
                cmd.op     = CMD_VEC_INIT;
                iter_next  = 5'd0;
                state_next = S_VITER;
            end
            S_VITER: begin
                cmd.op  = CMD_ITER;
                cmd.vec = 1'b1;
                if (iter_reg == LAST_ITER) begin
                    state_next = S_ANGLE;
                end else begin
                    iter_next = iter_reg + 5'd1;
                end
            end
            S_ANGLE: begin
                cmd.op     = CMD_ANGLE;
                state_next = S_RINIT;
            end
            S_RINIT: begin
                cmd.op     = CMD_ROT_INIT;
                iter_next  = 5'd0;
                state_next = S_RITER;
            end
            S_RITER: begin
                cmd.op = CMD_ITER;
                if (iter_reg == LAST_ITER) begin
                    state_next = S_MULG;
                end else begin
                    iter_next = iter_reg + 5'd1;
                end
            end
            S_MULG: begin
                cmd.op     = CMD_MUL_GAIN;
                state_next = S_RNDG;
            end
            S_RNDG: begin
                cmd.op     = CMD_RND_GAIN;
                state_next = S_MULR;
            end
            S_MULR: begin
                cmd.op     = CMD_MUL_RAD;
                state_next = S_SPD;
            end
            S_SPD: begin
                cmd.op = CMD_SPEED;
                if (wheel_reg == 2'(NUM_WHEELS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    wheel_next = wheel_reg + 2'd1;
                    state_next = S_VEL;
                end
            end
            S_DONE: begin
                if (!status.out_busy) begin
                    cmd.op     = CMD_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iter_reg  <= 5'd0;
            wheel_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            wheel_reg <= wheel_next;
        end
    end

endmodule

// File: rtl/sdik_datapath.sv
// Datapath of the swerve-drive kinematics block: registers, shared multiplier and shared CORDIC.
// Depends on sdik_pkg; driven by commands from sdik_ctrl.
module sdik_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic [71:0]          s_tdata,
    output logic [255:0]         m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  sdik_pkg::dp_cmd_t    cmd,
    output sdik_pkg::dp_status_t status
);
    import sdik_pkg::*;

    logic [17:0] hl_reg, hw_reg;
    logic [23:0] ir_reg;
    logic [31:0] ms_reg;

    logic signed [23:0] ux_reg, uy_reg, uq_reg;
    logic signed [63:0] prod_reg;
    logic signed [41:0] pw_reg, pl_reg;
    logic signed [27:0] vx_reg, vy_reg;
    logic [63:0]        sqx_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] s2_reg;
    logic [31:0]        ang_reg [NUM_WHEELS];
    logic [31:0]        spd_reg [NUM_WHEELS];
    logic [255:0]       out_data_reg;
    logic               out_valid_reg;

    // Shared multiplier, operands chosen by the command.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_full;

    always_comb begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        case (cmd.op)
            CMD_MUL_W: begin
                mul_a = $signed({14'd0, hw_reg});
                mul_b = {{8{uq_reg[23]}}, uq_reg};
            end
            CMD_MUL_L: begin
                mul_a = $signed({14'd0, hl_reg});
                mul_b = {{8{uq_reg[23]}}, uq_reg};
            end
            CMD_SQ_X: begin
                mul_a = {{4{vx_reg[27]}}, vx_reg};
                mul_b = {{4{vx_reg[27]}}, vx_reg};
            end
            CMD_SQ_Y: begin
                mul_a = {{4{vy_reg[27]}}, vy_reg};
                mul_b = {{4{vy_reg[27]}}, vy_reg};
            end
            CMD_MUL_GAIN: begin
                mul_a = cx_reg;
                mul_b = INV_GAIN;
            end
            CMD_MUL_RAD: begin
                mul_a = s2_reg;
                mul_b = $signed({8'd0, ir_reg});
            end
            default: ;
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Wheel velocity: the yaw-rate products are shared, only their signs depend on the wheel.
    logic signed [43:0] ux_e, uy_e, pw_e, pl_e, vx_full, vy_full;
    assign ux_e    = {{4{ux_reg[23]}}, ux_reg, 16'd0};
    assign uy_e    = {{4{uy_reg[23]}}, uy_reg, 16'd0};
    assign pw_e    = {{2{pw_reg[41]}}, pw_reg};
    assign pl_e    = {{2{pl_reg[41]}}, pl_reg};
    assign vx_full = cmd.wheel[0] ? (ux_e + pw_e) : (ux_e - pw_e);
    assign vy_full = cmd.wheel[1] ? (uy_e - pl_e) : (uy_e + pl_e);

    logic signed [31:0] vx32, vy32;
    assign vx32 = {{4{vx_reg[27]}}, vx_reg};
    assign vy32 = {{4{vy_reg[27]}}, vy_reg};

    logic [63:0] mag;
    assign mag        = sqx_reg + $unsigned(prod_reg);
    assign status.big = mag > {32'd0, ms_reg};
    assign status.out_busy = out_valid_reg && !m_tready;

    // Rotation target: minus the low 16 bits of the stored angle, in fine units.
    logic [31:0]        ang_sel;
    logic signed [16:0] th17;
    logic signed [31:0] th;
    assign ang_sel = ang_reg[cmd.wheel];
    assign th17    = -$signed({ang_sel[15], ang_sel[15:0]});
    assign th      = {th17[16:0], 15'd0};

    // One CORDIC micro-rotation; both modes share it.
    logic signed [31:0] dx, dy, at;
    logic               neg;
    assign dx  = cy_reg >>> cmd.iter;
    assign dy  = cx_reg >>> cmd.iter;
    assign at  = atan_entry(cmd.iter);
    assign neg = cmd.vec ? cy_reg[31] : !cz_reg[31];

    // Angle update: the change is folded into (-pi/2, pi/2] from the low 15 bits alone.
    logic signed [31:0] zr;
    logic [14:0]        t15;
    logic signed [16:0] r17;
    assign zr  = cz_reg + 32'sd16384;
    assign t15 = zr[29:15] + 15'd16383 - ang_sel[14:0];
    assign r17 = $signed({2'b00, t15}) - 17'sd16383;

    logic signed [63:0] g_rnd, w_rnd;
    logic signed [47:0] wq;
    logic [31:0]        w_sat;
    assign g_rnd = prod_reg + 64'sd536870912;
    assign w_rnd = prod_reg + 64'sd32768;
    assign wq    = w_rnd[63:16];

    always_comb begin
        if (wq[47:31] == {17{wq[47]}}) begin
            w_sat = wq[31:0];
        end else if (wq[47]) begin
            w_sat = 32'h8000_0000;
        end else begin
            w_sat = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hl_reg        <= 18'd24576;
            hw_reg        <= 18'd24576;
            ir_reg        <= 24'd327680;
            ms_reg        <= 32'd42950;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                ang_reg[i] <= 32'd0;
            end
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    CFG_HALF_LENGTH:  hl_reg <= cfg_wdata[17:0];
                    CFG_HALF_WIDTH:   hw_reg <= cfg_wdata[17:0];
                    CFG_INV_RADIUS:   ir_reg <= cfg_wdata[23:0];
                    CFG_MIN_SPEED_SQ: ms_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.op == CMD_ANGLE) begin
                ang_reg[cmd.wheel] <= ang_sel + {{15{r17[16]}}, r17};
            end
            if (cmd.op == CMD_PUBLISH) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            CMD_LOAD: begin
                ux_reg <= s_tdata[23:0];
                uy_reg <= s_tdata[47:24];
                uq_reg <= s_tdata[71:48];
            end
            CMD_MUL_W: prod_reg <= prod_full;
            CMD_MUL_L: begin
                pw_reg   <= prod_reg[41:0];
                prod_reg <= prod_full;
            end
            CMD_SAVE_L: pl_reg <= prod_reg[41:0];
            CMD_VEL: begin
                vx_reg <= vx_full[43:16];
                vy_reg <= vy_full[43:16];
            end
            CMD_SQ_X: prod_reg <= prod_full;
            CMD_SQ_Y: begin
                sqx_reg  <= $unsigned(prod_reg);
                prod_reg <= prod_full;
            end
            CMD_VEC_INIT: begin
                if (vx32 < 0) begin
                    if (vy32 >= 0) begin
                        cx_reg <= vy32;
                        cy_reg <= -vx32;
                        cz_reg <= HALF_PI_FINE;
                    end else begin
                        cx_reg <= -vy32;
                        cy_reg <= vx32;
                        cz_reg <= -HALF_PI_FINE;
                    end
                end else begin
                    cx_reg <= vx32;
                    cy_reg <= vy32;
                    cz_reg <= 32'sd0;
                end
            end
            CMD_ROT_INIT: begin
                if (th > HALF_PI_FINE) begin
                    cx_reg <= -vy32;
                    cy_reg <= vx32;
                    cz_reg <= th - HALF_PI_FINE;
                end else if (th < -HALF_PI_FINE) begin
                    cx_reg <= vy32;
                    cy_reg <= -vx32;
                    cz_reg <= th + HALF_PI_FINE;
                end else begin
                    cx_reg <= vx32;
                    cy_reg <= vy32;
                    cz_reg <= th;
                end
            end
            CMD_ITER: begin
                if (neg) begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - at;
                end else begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + at;
                end
            end
            CMD_MUL_GAIN: prod_reg <= prod_full;
            CMD_RND_GAIN: s2_reg <= g_rnd[61:30];
            CMD_MUL_RAD:  prod_reg <= prod_full;
            CMD_SPEED:    spd_reg[cmd.wheel] <= w_sat;
            CMD_PUBLISH: begin
                out_data_reg <= {spd_reg[3], spd_reg[2], spd_reg[1], spd_reg[0],
                                 ang_reg[3], ang_reg[2], ang_reg[1], ang_reg[0]};
            end
            default: ;
        endcase
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

endmodule

// File: rtl/swerve_drive_inverse_kinematics.sv
// Top level of the swerve-drive inverse kinematics block.
// Depends on sdik_pkg, sdik_ctrl and sdik_datapath.
//
// Channel   Direction  Transfer when           Contents
// s_*       in         s_tvalid && s_tready    one body twist (ux, uy, uq)
// m_*       out        m_tvalid && m_tready    four steering angles, four wheel speeds
// cfg_*     in         cfg_wen                 one configuration register write
//
// For each item the block loads the twist and forms the yaw-rate products, then per wheel
// forms the velocity and its squared magnitude on the shared multiplier, runs the vectoring
// CORDIC when the wheel is fast enough to steer, runs the rotation CORDIC, and scales the
// speed on the shared multiplier; last it publishes the result. It takes no new twist until
// the result of the last one is published.
// Reset is synchronous and active low; it restores the register defaults and zeros the
// stored steering angles. A finished result waits in the output register, so a stalled
// m_tready only holds the block when the next result is ready to be published.
module swerve_drive_inverse_kinematics (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wen,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,  // ux [23:0], uy [47:24], uq [71:48]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata   // angle_fr, angle_rr, angle_fl, angle_rl,
                                   // speed_fr, speed_rr, speed_fl, speed_rl, 32 bits each
);
    import sdik_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller walks the four wheels in turn and issues the datapath commands one by one.
    sdik_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds configuration, the steering angles and the output register.
    sdik_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: rtl/sdik_checker.sv
// Port-level checks of the swerve-drive kinematics block, bound to its top level.
// Depends only on the top level's ports.
module sdik_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    // One item at a time: after an input transfer the block is busy.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was still in work");

    // A result only appears at the end of an item's work, never from idle.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in work");

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped before transfer");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind swerve_drive_inverse_kinematics sdik_checker u_sdik_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
